FILE: rtl/smcos_pkg.sv
// shared constants, codes and controller/datapath types for the spread crossover unit
package smcos_pkg;

    // history storage
    localparam int HISTORY_DEPTH = 64;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(HISTORY_DEPTH - 1);

    // item field widths
    localparam int INSTR_W  = 2;
    localparam int PRICE_W  = 31;
    localparam int HELD_W   = 16;
    localparam int QTY_W    = 16;
    localparam int PERIOD_W = 6;
    localparam int ENTRY_W  = 2 * PRICE_W;

    // spread arithmetic
    localparam int SPREAD_W = PRICE_W + 1;
    localparam int SUM_W    = SPREAD_W + PERIOD_W;
    localparam int MULX_W   = SUM_W + 1;
    localparam int CMP_W    = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_AVERAGE_PERIOD = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_OPEN_QUANTITY  = 1'b1;
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET       = PERIOD_W'(1);

    // instrument codes
    localparam logic [INSTR_W-1:0] INSTR_MAIN = 2'd0;
    localparam logic [INSTR_W-1:0] INSTR_SUB  = 2'd1;

    // order codes
    localparam logic SIDE_BUY     = 1'b0;
    localparam logic SIDE_SELL    = 1'b1;
    localparam logic OFFSET_OPEN  = 1'b0;
    localparam logic OFFSET_CLOSE = 1'b1;

    // product slots for the scaled compares
    localparam logic [1:0] MUL_CUR_ASK  = 2'd0;
    localparam logic [1:0] MUL_PREV_ASK = 2'd1;
    localparam logic [1:0] MUL_CUR_BID  = 2'd2;
    localparam logic [1:0] MUL_PREV_BID = 2'd3;

    typedef logic [ENTRY_W-1:0] t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_SETUP,
        S_WALK,
        S_DRAIN,
        S_MUL,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic fetch;
        logic write;
        logic setup;
        logic walk;
        logic mul;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic ignored;
        logic enough;
        logic walk_last;
        logic mul_last;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/smcos_ctrl.sv
// sequencing state machine for the spread crossover unit
module smcos_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  smcos_pkg::t_sts i_sts,
    output smcos_pkg::t_cmd o_cmd
);
    import smcos_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: begin
                n_state = i_sts.ignored ? S_DONE : S_WRITE;
            end
            S_WRITE: begin
                n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = i_sts.enough ? S_WALK : S_DONE;
            end
            S_WALK: begin
                if (i_sts.walk_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (i_sts.mul_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_READ: begin
                o_cmd.fetch = 1'b1;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/smcos_dpath.sv
// history memories, window sums, scaled compares and order decision
module smcos_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  smcos_pkg::t_cmd                 i_cmd,
    output smcos_pkg::t_sts                 o_sts,
    input  logic [smcos_pkg::PERIOD_W-1:0]  i_period,
    input  logic [smcos_pkg::QTY_W-1:0]     i_open_qty,
    input  logic [smcos_pkg::INSTR_W-1:0]   i_instrument,
    input  logic [smcos_pkg::PRICE_W-1:0]   i_bid_price,
    input  logic [smcos_pkg::PRICE_W-1:0]   i_ask_price,
    input  logic [smcos_pkg::HELD_W-1:0]    i_short_held,
    input  logic [smcos_pkg::HELD_W-1:0]    i_long_held,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_quote_taken,
    output logic                            o_order_valid,
    output logic                            o_order_side,
    output logic                            o_order_offset,
    output logic [smcos_pkg::QTY_W-1:0]     o_order_quantity
);
    import smcos_pkg::*;

    // history memories
    t_entry mem_main [HISTORY_DEPTH];
    t_entry mem_sub  [HISTORY_DEPTH];

    // latched item
    logic [INSTR_W-1:0] r_instr;
    logic [PRICE_W-1:0] r_bid;
    logic [PRICE_W-1:0] r_ask;
    logic [HELD_W-1:0]  r_short;
    logic [HELD_W-1:0]  r_long;

    // history bookkeeping
    logic [PTR_W-1:0]   r_wp;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   r_walk_addr;
    t_entry             r_rd_main;
    t_entry             r_rd_sub;
    logic               r_rd_valid;
    logic [PERIOD_W-1:0] r_k;
    logic [PERIOD_W-1:0] r_rd_k;
    logic               r_walked;

    // window sums and reference spreads
    logic signed [SUM_W-1:0]    r_sum_bid;
    logic signed [SUM_W-1:0]    r_sum_ask;
    logic signed [SPREAD_W-1:0] r_cur_bid;
    logic signed [SPREAD_W-1:0] r_cur_ask;
    logic signed [SPREAD_W-1:0] r_prev_bid;
    logic signed [SPREAD_W-1:0] r_prev_ask;
    logic [1:0]                 r_mul_idx;
    logic signed [SUM_W-1:0]    r_prod [4];

    // output register
    logic               r_out_valid;
    logic               r_taken;
    logic               r_order_valid;
    logic               r_side;
    logic               r_offset;
    logic [QTY_W-1:0]   r_qty;

    logic                       has_prev;
    logic                       is_main;
    t_entry                     new_entry;
    t_entry                     wr_main;
    t_entry                     wr_sub;
    logic [PTR_W-1:0]           wp_prev;
    logic [PERIOD_W-1:0]        k_last;
    logic signed [SPREAD_W-1:0] sp_bid;
    logic signed [SPREAD_W-1:0] sp_ask;
    logic signed [SPREAD_W-1:0] mul_op;
    logic signed [MULX_W-1:0]   mul_full;
    logic                       sell_cross;
    logic                       buy_cross;
    logic                       n_order_valid;
    logic                       n_side;
    logic                       n_offset;
    logic [QTY_W-1:0]           n_qty;

    // status to the controller
    assign has_prev   = (r_count != '0);
    assign k_last     = (i_period < PERIOD_W'(2)) ? PERIOD_W'(1) : i_period - PERIOD_W'(1);
    assign o_sts.ignored   = (r_instr != INSTR_MAIN) && (r_instr != INSTR_SUB);
    assign o_sts.enough    = (i_period != '0)
                          && (CMP_W'(r_count) >= CMP_W'(i_period))
                          && (r_count >= CNT_W'(2));
    assign o_sts.walk_last = (r_k == k_last);
    assign o_sts.mul_last  = (r_mul_idx == MUL_PREV_BID);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_instr <= i_instrument;
            r_bid   <= i_bid_price;
            r_ask   <= i_ask_price;
            r_short <= i_short_held;
            r_long  <= i_long_held;
        end
    end

    // aligned pair for the write: other leg carries its latest prices
    assign is_main   = (r_instr == INSTR_MAIN);
    assign new_entry = {r_ask, r_bid};
    assign wr_main   = is_main ? new_entry : (has_prev ? r_rd_main : '0);
    assign wr_sub    = is_main ? (has_prev ? r_rd_sub : '0) : new_entry;
    assign wp_prev   = (r_wp == '0) ? LAST_SLOT : r_wp - PTR_W'(1);

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem_main[r_wp] <= wr_main;
            mem_sub[r_wp]  <= wr_sub;
        end
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch || i_cmd.walk) begin
            r_rd_main <= mem_main[r_walk_addr];
            r_rd_sub  <= mem_sub[r_walk_addr];
        end
    end

    // read address walks back from the newest pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_walk_addr <= wp_prev;
        end else if (i_cmd.write) begin
            r_walk_addr <= r_wp;
        end else if (i_cmd.walk) begin
            r_walk_addr <= (r_walk_addr == '0) ? LAST_SLOT : r_walk_addr - PTR_W'(1);
        end
    end

    // write pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_count <= '0;
        end else if (i_cmd.write) begin
            r_wp <= (r_wp == LAST_SLOT) ? '0 : r_wp + PTR_W'(1);
            if (r_count != CNT_W'(HISTORY_DEPTH)) r_count <= r_count + CNT_W'(1);
        end
    end

    // walk step counter and read tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_k        <= '0;
            r_walked   <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.walk;
            if (i_cmd.accept) begin
                r_walked <= 1'b0;
            end else if (i_cmd.setup) begin
                r_walked <= o_sts.enough;
            end
            if (i_cmd.setup) begin
                r_k <= '0;
            end else if (i_cmd.walk) begin
                r_k <= r_k + PERIOD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_k <= r_k;
    end

    // spreads of the pair just read
    assign sp_bid = $signed({1'b0, r_rd_main[PRICE_W-1:0]})
                  - $signed({1'b0, r_rd_sub[PRICE_W-1:0]});
    assign sp_ask = $signed({1'b0, r_rd_main[ENTRY_W-1:PRICE_W]})
                  - $signed({1'b0, r_rd_sub[ENTRY_W-1:PRICE_W]});

    // window accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_sum_bid <= '0;
            r_sum_ask <= '0;
        end else if (r_rd_valid) begin
            if (r_rd_k < i_period) begin
                r_sum_bid <= r_sum_bid + SUM_W'(sp_bid);
                r_sum_ask <= r_sum_ask + SUM_W'(sp_ask);
            end
            if (r_rd_k == PERIOD_W'(0)) begin
                r_cur_bid <= sp_bid;
                r_cur_ask <= sp_ask;
            end
            if (r_rd_k == PERIOD_W'(1)) begin
                r_prev_bid <= sp_bid;
                r_prev_ask <= sp_ask;
            end
        end
    end

    // shared multiplier: one scaled spread per cycle
    always_comb begin
        unique case (r_mul_idx)
            MUL_CUR_ASK:  mul_op = r_cur_ask;
            MUL_PREV_ASK: mul_op = r_prev_ask;
            MUL_CUR_BID:  mul_op = r_cur_bid;
            MUL_PREV_BID: mul_op = r_prev_bid;
            default:      mul_op = r_cur_ask;
        endcase
    end

    assign mul_full = MULX_W'(mul_op) * $signed(MULX_W'({1'b0, i_period}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_idx <= MUL_CUR_ASK;
        end else if (i_cmd.setup) begin
            r_mul_idx <= MUL_CUR_ASK;
        end else if (i_cmd.mul) begin
            r_mul_idx <= r_mul_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod[r_mul_idx] <= mul_full[SUM_W-1:0];
        end
    end

    // crossover tests
    assign sell_cross = r_walked
                     && (r_prod[MUL_CUR_ASK] < r_sum_bid)
                     && (r_sum_bid < r_prod[MUL_PREV_ASK]);
    assign buy_cross  = r_walked
                     && (r_prod[MUL_CUR_BID] < r_sum_ask)
                     && (r_sum_ask < r_prod[MUL_PREV_BID]);

    // order decision: a held position closes only on its matching cross; flat, open sell before buy
    always_comb begin
        n_order_valid = 1'b0;
        n_side        = SIDE_BUY;
        n_offset      = OFFSET_OPEN;
        n_qty         = '0;
        priority if (o_sts.ignored) begin
            n_order_valid = 1'b0;
        end else if (r_short != '0) begin
            if (buy_cross) begin
                n_order_valid = 1'b1;
                n_side        = SIDE_BUY;
                n_offset      = OFFSET_CLOSE;
                n_qty         = r_short;
            end
        end else if (r_long != '0) begin
            if (sell_cross) begin
                n_order_valid = 1'b1;
                n_side        = SIDE_SELL;
                n_offset      = OFFSET_CLOSE;
                n_qty         = r_long;
            end
        end else if (sell_cross) begin
            n_order_valid = 1'b1;
            n_side        = SIDE_SELL;
            n_offset      = OFFSET_OPEN;
            n_qty         = i_open_qty;
        end else if (buy_cross) begin
            n_order_valid = 1'b1;
            n_side        = SIDE_BUY;
            n_offset      = OFFSET_OPEN;
            n_qty         = i_open_qty;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_taken       <= !o_sts.ignored;
            r_order_valid <= n_order_valid;
            r_side        <= n_side;
            r_offset      <= n_offset;
            r_qty         <= n_qty;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_quote_taken    = r_taken;
    assign o_order_valid    = r_order_valid;
    assign o_order_side     = r_side;
    assign o_order_offset   = r_offset;
    assign o_order_quantity = r_qty;

`ifndef SYNTHESIS
    // fill count saturates at the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HISTORY_DEPTH))
        else $error("history count above depth");

    // write pointer stays inside the memory
    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= LAST_SLOT)
        else $error("write pointer out of range");

    // a window walk only runs with enough history
    a_walk_enough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |-> r_walked && (r_count >= CNT_W'(2)))
        else $error("walk without enough history");

    // an order only comes from a stored quote
    a_order_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_order_valid |-> r_taken)
        else $error("order on an ignored quote");

    // no order means empty order fields
    a_no_order_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_order_valid |->
            (r_side == SIDE_BUY) && (r_offset == OFFSET_OPEN) && (r_qty == '0))
        else $error("order fields set without an order");
`endif

endmodule

FILE: rtl/spread_ma_cross_order_signal_unit.sv
// top level of the spread moving-average crossover unit with its register port
//
//  channel   | signals                                   | moves
//  ----------+-------------------------------------------+----------------------------
//  quote in  | i_in_valid / o_in_ready                   | one quote item
//  result    | o_out_valid / i_out_ready                 | one result item per quote
//  registers | i_psel i_penable i_pwrite i_paddr i_pwdata | average_period, open_quantity
//
//  a stored quote is fetched, written and set up, then walked over the history read port
//  one pair per cycle, drained, multiplied and finished into the result register
//  an ignored quote goes from read to done, one with too little history from setup
//  the next quote is accepted once the current one has moved into the result register
//  a result that is not taken holds the next quote in its done state until it drains
//  reset clears pointer, fill count and registers; history memories need no clearing
module spread_ma_cross_order_signal_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // quote channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [smcos_pkg::INSTR_W-1:0]   i_instrument,
    input  logic [smcos_pkg::PRICE_W-1:0]   i_bid_price,
    input  logic [smcos_pkg::PRICE_W-1:0]   i_ask_price,
    input  logic [smcos_pkg::HELD_W-1:0]    i_short_held,
    input  logic [smcos_pkg::HELD_W-1:0]    i_long_held,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_quote_taken,
    output logic                            o_order_valid,
    output logic                            o_order_side,
    output logic                            o_order_offset,
    output logic [smcos_pkg::QTY_W-1:0]     o_order_quantity,
    // register port
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [smcos_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [smcos_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [smcos_pkg::PDATA_W-1:0]   o_prdata,
    output logic                            o_pready
);
    import smcos_pkg::*;

    logic [PERIOD_W-1:0]  r_period;
    logic [QTY_W-1:0]     r_open_qty;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 reg_wr;
    t_cmd                 cmd;
    t_sts                 sts;

    // register decode
    assign reg_idx  = i_paddr[PADDR_W-1:2];
    assign reg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RESET;
            r_open_qty <= '0;
        end else if (reg_wr) begin
            unique case (reg_idx)
                REG_AVERAGE_PERIOD: r_period   <= i_pwdata[PERIOD_W-1:0];
                REG_OPEN_QUANTITY:  r_open_qty <= i_pwdata[QTY_W-1:0];
                default:            r_period   <= r_period;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_AVERAGE_PERIOD: o_prdata = PDATA_W'(r_period);
            REG_OPEN_QUANTITY:  o_prdata = PDATA_W'(r_open_qty);
            default:            o_prdata = '0;
        endcase
    end

    // sequencing
    smcos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // history and decision datapath
    smcos_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_period         (r_period),
        .i_open_qty       (r_open_qty),
        .i_instrument     (i_instrument),
        .i_bid_price      (i_bid_price),
        .i_ask_price      (i_ask_price),
        .i_short_held     (i_short_held),
        .i_long_held      (i_long_held),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_quote_taken    (o_quote_taken),
        .o_order_valid    (o_order_valid),
        .o_order_side     (o_order_side),
        .o_order_offset   (o_order_offset),
        .o_order_quantity (o_order_quantity)
    );

endmodule

FILE: sim/tb_spread_ma_cross_order_signal_unit.sv
// self-checking testbench for the spread moving-average crossover order unit
module tb_spread_ma_cross_order_signal_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import smcos_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES   = 80;
    localparam int PHASE_ITEMS  = 80;
    localparam int ORDER_SLOTS  = 64;
    localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
    localparam logic [HELD_W-1:0]  HELD_MAX  = '1;
    localparam logic [QTY_W-1:0]   QTY_MAX   = '1;

    // quote codes that are not part of the pair
    localparam logic [INSTR_W-1:0] INSTR_OTHER = 2'd2;
    localparam logic [INSTR_W-1:0] INSTR_SPARE = 2'd3;

    // which price the window averages
    localparam bit AVG_OF_BIDS = 1'b0;
    localparam bit AVG_OF_ASKS = 1'b1;

    typedef struct {
        logic [INSTR_W-1:0] instrument;
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [HELD_W-1:0]  short_held;
        logic [HELD_W-1:0]  long_held;
    } t_quote;

    typedef struct {
        logic              quote_taken;
        logic              order_valid;
        logic              order_side;
        logic              order_offset;
        logic [QTY_W-1:0]  order_quantity;
    } t_order;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [INSTR_W-1:0]  i_instrument;
    logic [PRICE_W-1:0]  i_bid_price;
    logic [PRICE_W-1:0]  i_ask_price;
    logic [HELD_W-1:0]   i_short_held;
    logic [HELD_W-1:0]   i_long_held;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_quote_taken;
    logic                o_order_valid;
    logic                o_order_side;
    logic                o_order_offset;
    logic [QTY_W-1:0]    o_order_quantity;
    logic                i_psel;
    logic                i_penable;
    logic                i_pwrite;
    logic [PADDR_W-1:0]  i_paddr;
    logic [PDATA_W-1:0]  i_pwdata;
    logic [PDATA_W-1:0]  o_prdata;
    logic                o_pready;

    // predictor state: pair history, fill count, pointer and registers
    logic [PRICE_W-1:0]  main_bid [HISTORY_DEPTH];
    logic [PRICE_W-1:0]  main_ask [HISTORY_DEPTH];
    logic [PRICE_W-1:0]  sub_bid  [HISTORY_DEPTH];
    logic [PRICE_W-1:0]  sub_ask  [HISTORY_DEPTH];
    int                  hist_count = 0;
    logic [PTR_W-1:0]    hist_wp = '0;
    logic [PERIOD_W-1:0] cfg_period = PERIOD_RESET;
    logic [QTY_W-1:0]    cfg_open_qty = '0;

    // expected orders in accept order, a ring with running head and tail
    t_order expected_orders [ORDER_SLOTS];
    int     order_head = 0;
    int     order_tail = 0;
    int     mismatches = 0;
    int     cycles = 0;
    bit     stall_free = 1'b0;
    longint main_mid;
    longint sub_mid;

    spread_ma_cross_order_signal_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= stall_free || ($urandom_range(99) >= 26);
    end

    // spread of one stored pair, counted back from the newest
    function automatic longint leg_spread(int back, bit on_ask);
        logic [PTR_W-1:0] slot;
        slot = hist_wp - PTR_W'(1) - PTR_W'(back);
        if (on_ask)
            return longint'(main_ask[slot]) - longint'(sub_ask[slot]);
        return longint'(main_bid[slot]) - longint'(sub_bid[slot]);
    endfunction

    // scaled crossover test: current * P < window sum < previous * P
    function automatic bit spread_crosses(bit avg_ask);
        longint sum;
        longint scale;
        longint cur;
        longint prev;
        sum = 0;
        if (cfg_period == 0 || hist_count < cfg_period || hist_count < 2)
            return 1'b0;
        for (int k = 0; k < cfg_period; k++)
            sum += leg_spread(k, avg_ask);
        scale = longint'(cfg_period);
        cur  = leg_spread(0, !avg_ask) * scale;
        prev = leg_spread(1, !avg_ask) * scale;
        return (cur < sum) && (sum < prev);
    endfunction

    // store the quote as an aligned pair and decide the order
    function automatic t_order predict_order(t_quote q);
        t_order r;
        logic [PTR_W-1:0] last;
        r = '{default: '0};
        if (q.instrument != INSTR_MAIN && q.instrument != INSTR_SUB)
            return r;
        last = hist_wp - PTR_W'(1);
        if (q.instrument == INSTR_MAIN) begin
            sub_bid[hist_wp]  = (hist_count > 0) ? sub_bid[last] : '0;
            sub_ask[hist_wp]  = (hist_count > 0) ? sub_ask[last] : '0;
            main_bid[hist_wp] = q.bid;
            main_ask[hist_wp] = q.ask;
        end else begin
            main_bid[hist_wp] = (hist_count > 0) ? main_bid[last] : '0;
            main_ask[hist_wp] = (hist_count > 0) ? main_ask[last] : '0;
            sub_bid[hist_wp]  = q.bid;
            sub_ask[hist_wp]  = q.ask;
        end
        hist_wp = hist_wp + PTR_W'(1);
        if (hist_count < HISTORY_DEPTH)
            hist_count++;
        r.quote_taken = 1'b1;

        // held positions first, then open with sell ahead of buy
        if (q.short_held != 0) begin
            if (spread_crosses(AVG_OF_ASKS)) begin
                r.order_valid = 1'b1;
                r.order_side = SIDE_BUY;
                r.order_offset = OFFSET_CLOSE;
                r.order_quantity = q.short_held;
            end
        end else if (q.long_held != 0) begin
            if (spread_crosses(AVG_OF_BIDS)) begin
                r.order_valid = 1'b1;
                r.order_side = SIDE_SELL;
                r.order_offset = OFFSET_CLOSE;
                r.order_quantity = q.long_held;
            end
        end else if (spread_crosses(AVG_OF_BIDS)) begin
            r.order_valid = 1'b1;
            r.order_side = SIDE_SELL;
            r.order_offset = OFFSET_OPEN;
            r.order_quantity = cfg_open_qty;
        end else if (spread_crosses(AVG_OF_ASKS)) begin
            r.order_valid = 1'b1;
            r.order_side = SIDE_BUY;
            r.order_offset = OFFSET_OPEN;
            r.order_quantity = cfg_open_qty;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // compare each taken result with the oldest expected order
    always @(posedge i_clk) begin
        t_order want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (order_tail == order_head) begin
                $error("result with no quote pending");
                mismatches++;
            end else begin
                want = expected_orders[order_head % ORDER_SLOTS];
                order_head++;
                check_field("quote_taken", want.quote_taken, o_quote_taken);
                check_field("order_valid", want.order_valid, o_order_valid);
                check_field("order_side", want.order_side, o_order_side);
                check_field("order_offset", want.order_offset, o_order_offset);
                check_field("order_quantity", want.order_quantity, o_order_quantity);
            end
        end
    end

    function automatic t_quote make_quote(logic [INSTR_W-1:0] instrument,
                                          logic [PRICE_W-1:0] bid, logic [PRICE_W-1:0] ask,
                                          logic [HELD_W-1:0] short_held,
                                          logic [HELD_W-1:0] long_held);
        t_quote q;
        q.instrument = instrument;
        q.bid = bid;
        q.ask = ask;
        q.short_held = short_held;
        q.long_held = long_held;
        return q;
    endfunction

    // next quote of a drifting two-leg market, with some noise and jumps
    function automatic t_quote next_market_quote();
        t_quote q;
        int     pick;
        longint mid;
        pick = $urandom_range(99);
        if (pick < 8) begin
            q.instrument = INSTR_W'($urandom_range(3));
            q.bid = PRICE_W'($urandom);
            q.ask = PRICE_W'($urandom);
            q.short_held = HELD_W'($urandom);
            q.long_held = HELD_W'($urandom);
            return q;
        end
        if ($urandom_range(99) < 3)
            main_mid = longint'($urandom_range(2_000_000_000, 1000));
        if ($urandom_range(99) < 3)
            sub_mid = longint'($urandom_range(2_000_000_000, 1000));
        main_mid += longint'($urandom_range(400)) - 200;
        sub_mid  += longint'($urandom_range(400)) - 200;
        if (main_mid < 1000) main_mid = 1000;
        if (sub_mid < 1000) sub_mid = 1000;
        if (main_mid > 2_100_000_000) main_mid = 2_100_000_000;
        if (sub_mid > 2_100_000_000) sub_mid = 2_100_000_000;

        pick = $urandom_range(99);
        q.instrument = (pick < 46) ? INSTR_MAIN : (pick < 92) ? INSTR_SUB :
                       (pick < 96) ? INSTR_OTHER : INSTR_SPARE;
        mid = (q.instrument == INSTR_SUB) ? sub_mid : main_mid;
        q.bid = PRICE_W'(mid - longint'($urandom_range(15)));
        q.ask = PRICE_W'(mid + longint'($urandom_range(15)));

        // half flat, otherwise one side or both held
        pick = $urandom_range(99);
        q.short_held = '0;
        q.long_held = '0;
        if (pick >= 50 && pick < 70)
            q.short_held = HELD_W'($urandom_range(65535, 1));
        else if (pick >= 70 && pick < 90)
            q.long_held = HELD_W'($urandom_range(65535, 1));
        else if (pick >= 90) begin
            q.short_held = HELD_W'($urandom);
            q.long_held = HELD_W'($urandom);
        end
        return q;
    endfunction

    // present one item, wait for its accept, then record the expected order
    task automatic send_quote(input t_quote q);
        if (!stall_free && $urandom_range(99) < 26) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(60, 1)) @(negedge i_clk);
        end
        i_instrument = q.instrument;
        i_bid_price  = q.bid;
        i_ask_price  = q.ask;
        i_short_held = q.short_held;
        i_long_held  = q.long_held;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        expected_orders[order_tail % ORDER_SLOTS] = predict_order(q);
        order_tail++;
        @(negedge i_clk);
    endtask

    // stop sending and let every pending order come out
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (order_tail != order_head) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [PDATA_W-1:0] value);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = PADDR_W'({idx, 2'b00});
        i_pwdata  = value;
        @(negedge i_clk);
        i_penable = 1'b1;
        do @(posedge i_clk); while (!o_pready);
        case (idx)
            REG_AVERAGE_PERIOD: cfg_period = value[PERIOD_W-1:0];
            REG_OPEN_QUANTITY:  cfg_open_qty = value[QTY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
    endtask

    // write both registers, with random unused upper bits
    task automatic configure(input logic [PERIOD_W-1:0] period, input logic [QTY_W-1:0] qty);
        logic [PDATA_W-1:0] word;
        word = $urandom;
        word[PERIOD_W-1:0] = period;
        write_register(REG_AVERAGE_PERIOD, word);
        word = $urandom;
        word[QTY_W-1:0] = qty;
        write_register(REG_OPEN_QUANTITY, word);
    endtask

    // reset values: period 1, open size 0, crosses on the second, third and fourth pairs, ignored codes
    task automatic test_startup_defaults();
        send_quote(make_quote(INSTR_MAIN, 1000, 1100, 0, 0));
        send_quote(make_quote(INSTR_SUB, 900, 903, 0, 0));
        send_quote(make_quote(INSTR_MAIN, 1050, 1051, 0, 0));
        send_quote(make_quote(INSTR_OTHER, PRICE_W'($urandom), PRICE_W'($urandom),
                              HELD_W'($urandom), HELD_W'($urandom)));
        send_quote(make_quote(INSTR_SPARE, PRICE_MAX, PRICE_MAX, HELD_MAX, HELD_MAX));
        send_quote(make_quote(INSTR_MAIN, 1000, 1010, 7, 0));
        drain_results();
    endtask

    // window longer than the stored history never signals
    task automatic test_short_history();
        configure(6'd63, QTY_MAX);
        main_mid = 50_000;
        sub_mid = 49_000;
        repeat (6) send_quote(next_market_quote());
        drain_results();
    endtask

    // price and holding extremes on both legs
    task automatic test_price_extremes();
        configure(6'd2, 16'h1234);
        send_quote(make_quote(INSTR_MAIN, PRICE_MAX, PRICE_MAX, 0, HELD_MAX));
        send_quote(make_quote(INSTR_SUB, 0, 0, HELD_MAX, 0));
        send_quote(make_quote(INSTR_MAIN, 0, PRICE_MAX, HELD_MAX, HELD_MAX));
        send_quote(make_quote(INSTR_SUB, PRICE_MAX, 0, 0, 0));
        send_quote(make_quote(INSTR_MAIN, PRICE_MAX, 0, 0, 1));
        send_quote(make_quote(INSTR_SUB, 0, PRICE_MAX, 1, 0));
        send_quote(make_quote(INSTR_SPARE, 0, 0, 0, 0));
        send_quote(make_quote(INSTR_MAIN, 12345, 12400, 0, 0));
        send_quote(make_quote(INSTR_SUB, 0, 0, 0, 0));
        send_quote(make_quote(INSTR_MAIN, PRICE_MAX, PRICE_MAX, 0, 0));
        drain_results();
    endtask

    // drifting market across a sweep of period and order size settings
    task automatic test_random_walk();
        logic [PERIOD_W-1:0] period;
        logic [QTY_W-1:0]    qty;
        main_mid = longint'($urandom_range(2_000_000_000, 1000));
        sub_mid = main_mid + longint'($urandom_range(2000)) - 1000;
        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0: period = 6'd1;
                1: period = 6'd2;
                2: period = 6'd63;
                3: period = 6'd0;
                4: period = 6'd3;
                default: period = ($urandom_range(3) == 0) ?
                                  PERIOD_W'($urandom_range(63, 1)) :
                                  PERIOD_W'($urandom_range(8, 1));
            endcase
            case (phase % 4)
                0: qty = QTY_MAX;
                1: qty = '0;
                default: qty = QTY_W'($urandom);
            endcase
            configure(period, qty);
            repeat (PHASE_ITEMS) send_quote(next_market_quote());
            drain_results();
        end
    endtask

    // back-to-back items with the result side always ready
    task automatic test_no_stall();
        configure(6'd4, QTY_W'($urandom));
        stall_free = 1'b1;
        repeat (100) send_quote(next_market_quote());
        drain_results();
        stall_free = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_instrument = '0;
        i_bid_price  = '0;
        i_ask_price  = '0;
        i_short_held = '0;
        i_long_held  = '0;
        i_psel       = 1'b0;
        i_penable    = 1'b0;
        i_pwrite     = 1'b0;
        i_paddr      = '0;
        i_pwdata     = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_startup_defaults();
        test_short_history();
        test_price_extremes();
        test_random_walk();
        test_no_stall();

        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && order_tail == order_head)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
